// File: design/assert_macros.svh
// assertion macros shared by the record store design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define AOTRS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AOTRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/aotrs_pkg.sv
// types, constants and helper functions of the record store
`default_nettype none
package aotrs_pkg;

	localparam int CELL_COUNT   = 64;
	localparam int CELL_BYTES   = 8;
	localparam int HEADER_BYTES = 3;
	localparam int PAYLOAD_ROOM = CELL_BYTES - HEADER_BYTES;
	localparam int VALUE_BYTES  = 5;
	localparam int VALUE_W      = 8 * VALUE_BYTES;
	localparam int ADDR_W       = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam int CNT_W        = $clog2(CELL_COUNT + 1);

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_INVALID   = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_CORRUPT   = 3'd4;

	localparam logic [7:0] VERSION_RESET = 8'd1;

	typedef struct packed {
		logic               opcode;
		logic [7:0]         record_type;
		logic [7:0]         record_length;
		logic [VALUE_W-1:0] record_value;
		logic [7:0]         read_capacity;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [2:0]         found_length;
		logic [VALUE_W-1:0] found_value;
	} out_item_t;

	// one stored cell: header bytes plus the masked payload
	typedef struct packed {
		logic [7:0]         version;
		logic [7:0]         rtype;
		logic [7:0]         length;
		logic [VALUE_W-1:0] payload;
	} cell_t;

	localparam int CELL_W = $bits(cell_t);

	typedef struct packed {
		logic               hit;
		logic [2:0]         status;
		logic [2:0]         flen;
		logic [VALUE_W-1:0] fval;
	} cmp_res_t;

	// ones over the low n payload bytes, capped at the field width
	function automatic logic [VALUE_W-1:0] byte_mask(input logic [7:0] n);
		logic [VALUE_W-1:0] m;
		m = '0;
		for (int b = 0; b < VALUE_BYTES; b++) begin
			m[8*b +: 8] = (n > 8'(b)) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// File: design/aotrs_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module aotrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic                                       re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: design/aotrs_cmp.sv
// match and classify unit, shared by every cell of a lookup scan
`default_nettype none
module aotrs_cmp (
	input  wire aotrs_pkg::cell_t    entry,
	input  wire logic [7:0]          version,
	input  wire logic [7:0]          rtype,
	input  wire logic [7:0]          capacity,
	output      aotrs_pkg::cmp_res_t res
);
	import aotrs_pkg::*;

	always_comb begin
		res.hit    = (entry.version == version) && (entry.rtype == rtype);
		res.status = ST_OK;
		res.flen   = '0;
		res.fval   = '0;
		if (entry.length > 8'(PAYLOAD_ROOM)) begin
			res.status = ST_CORRUPT;
		end else if (entry.length > capacity) begin
			res.status = ST_INVALID;
			res.flen   = entry.length[2:0];
		end else begin
			// payload was masked on append, so it already reads as stored
			res.flen   = entry.length[2:0];
			res.fval   = entry.payload;
		end
	end

endmodule
`default_nettype wire

// File: design/append_only_tagged_record_store_unit.sv
// top level of the append-only tagged record store
//
// channel   direction  handshake            payload
// in        input      in_valid / in_ready   aotrs_pkg::in_item_t
// out       output     out_valid / out_ready aotrs_pkg::out_item_t
// cfg       input      cfg_we                cfg_wdata (record_version)
//
// an append is accepted (the cell is written then) and then handed off;
// a lookup reads one stored cell at a time, newest first, up to a match or the oldest;
// a zero-capacity or empty-store lookup skips the scan; the single ram read port sets this
// in_ready is high only while the sequencer idles; a finished result waits in
// the output register, so a new transaction can be taken while out is stalled
// reset clears the fill count and all control state; the version resets to VERSION_RESET;
// cells are never read before being written, so the ram needs no clearing pass
`default_nettype none
`include "assert_macros.svh"
module append_only_tagged_record_store_unit (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output      logic                  in_ready,
	input  wire aotrs_pkg::in_item_t   in_data,
	output      logic                  out_valid,
	input  wire logic                  out_ready,
	output      aotrs_pkg::out_item_t  out_data,
	input  wire logic                  cfg_we,
	input  wire logic [7:0]            cfg_wdata
);
	import aotrs_pkg::*;

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  count_q;       // cells written so far
	logic [7:0]        version_q;
	logic [ADDR_W-1:0] addr_q;        // next cell to read
	logic              issue_q;       // reads still to issue
	logic              chk_q;         // read data arrives this cycle
	logic              chk_last_q;    // ...and it is the oldest cell
	logic              out_valid_q;

	// payload registers
	logic [7:0]        req_type_q;
	logic [7:0]        req_cap_q;
	out_item_t         res_q;
	out_item_t         out_q;

	// datapath
	logic              accept;
	logic              full;
	logic              arg_ok;
	logic              ram_we;
	logic [ADDR_W-1:0] free_addr;
	logic [ADDR_W-1:0] start_addr;
	logic [VALUE_W-1:0] app_mask;
	cell_t             wcell;
	cell_t             rcell;
	logic              ram_re;
	cmp_res_t          cmp;
	logic              out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = (count_q == CNT_W'(CELL_COUNT));
	assign arg_ok    = (in_data.record_type != 8'd0) && (in_data.record_length != 8'd0) &&
	                   (in_data.record_length <= 8'(PAYLOAD_ROOM));
	// appends grow downward from the top cell, so the newest sits lowest
	assign free_addr  = ADDR_W'(CNT_W'(CELL_COUNT - 1) - count_q);
	assign start_addr = ADDR_W'(CNT_W'(CELL_COUNT) - count_q);
	assign app_mask   = byte_mask(in_data.record_length);

	assign ram_we = accept && (in_data.opcode == OP_APPEND) && arg_ok && !full;
	assign ram_re = (state_q == S_SCAN) && issue_q;

	always_comb begin
		wcell.version = version_q;
		wcell.rtype   = in_data.record_type;
		wcell.length  = in_data.record_length;
		wcell.payload = (in_data.record_value & app_mask) | ~app_mask;
	end

	aotrs_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_addr),
		.wdata (wcell),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (rcell)
	);

	aotrs_cmp u_cmp (
		.entry    (rcell),
		.version  (version_q),
		.rtype    (req_type_q),
		.capacity (req_cap_q),
		.res      (cmp)
	);

	// the output register takes a result when empty or being drained
	assign out_free = !out_valid_q || out_ready;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			version_q   <= VERSION_RESET;
			addr_q      <= '0;
			issue_q     <= 1'b0;
			chk_q       <= 1'b0;
			chk_last_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				version_q <= cfg_wdata;
			end
			if (ram_we) begin
				count_q <= count_q + CNT_W'(1);
			end

			// output register hand-off
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					chk_q      <= 1'b0;
					chk_last_q <= 1'b0;
					if (accept) begin
						if (in_data.opcode == OP_LOOKUP && in_data.read_capacity != 8'd0 &&
						    count_q != '0) begin
							addr_q  <= start_addr;
							issue_q <= 1'b1;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (chk_q && (cmp.hit || chk_last_q)) begin
						// first match, or the oldest cell checked
						issue_q    <= 1'b0;
						chk_q      <= 1'b0;
						chk_last_q <= 1'b0;
						state_q    <= S_DONE;
					end else begin
						// one read issued and one cell checked per cycle
						chk_q      <= issue_q;
						chk_last_q <= issue_q && (addr_q == LAST_ADDR);
						if (issue_q) begin
							if (addr_q == LAST_ADDR) begin
								issue_q <= 1'b0;
							end else begin
								addr_q <= addr_q + ADDR_W'(1);
							end
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q         <= in_data.record_type;
			req_cap_q          <= in_data.read_capacity;
			res_q.found_length <= '0;
			res_q.found_value  <= '0;
			if (in_data.opcode == OP_APPEND) begin
				if (!arg_ok) begin
					res_q.status <= ST_INVALID;
				end else if (full) begin
					res_q.status <= ST_FULL;
				end else begin
					res_q.status <= ST_OK;
				end
			end else if (in_data.read_capacity == 8'd0) begin
				res_q.status <= ST_INVALID;
			end else begin
				// empty store, or the scan finding nothing, reads as not found
				res_q.status <= ST_NOT_FOUND;
			end
		end
		if (state_q == S_SCAN && chk_q && cmp.hit) begin
			res_q.status       <= cmp.status;
			res_q.found_length <= cmp.flen;
			res_q.found_value  <= cmp.fval;
		end
		if (state_q == S_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`AOTRS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !in_ready,
		"input taken again right after a transaction")
	`AOTRS_ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(CELL_COUNT),
		"fill count above cell count")
	`AOTRS_ASSERT_IMPLIES(a_write_on_accept, clk, arst_n, ram_we, accept && !full,
		"cell write outside an accepted append")
	`AOTRS_ASSERT_IMPLIES(a_scan_nonempty, clk, arst_n, state_q == S_SCAN, count_q != '0,
		"scan running over an empty store")

endmodule
`default_nettype wire
